/* rtl/core/kbsc_pkg.sv */
// shared types and constants for the keyed byte substitution cipher core
// no dependencies
package kbsc_pkg;

	localparam int KEY_MAX_LEN = 64;
	localparam int KEY_AW      = 6;
	localparam int LEN_W       = 7;
	localparam int BYTE_VALS   = 256;
	localparam int CNT_W       = 9;
	localparam int MIX_W       = 64;
	localparam int SUM_W       = 14;
	localparam int DIV_CW      = 6;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_START  = 2'd1;
	localparam logic [1:0] REQ_DATA   = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic CFG_KEY_LENGTH = 1'b0;
	localparam logic CFG_DIRECTION  = 1'b1;

	localparam logic [8:0] STEP_FIRST = 9'h102;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR,
		ST_KX,
		ST_KY,
		ST_KYW,
		ST_P_RD,
		ST_P_DEC,
		ST_TA_RD,
		ST_TA_WR,
		ST_TB_RD,
		ST_TB_WR,
		ST_P_NEXT,
		ST_D_RD,
		ST_D_CAP,
		ST_S_RD,
		ST_S_WR,
		ST_M_RD,
		ST_M_ACC,
		ST_DV,
		ST_F_RD,
		ST_F_WR,
		ST_N_RD,
		ST_N_WR,
		ST_E_RD,
		ST_E_CAP,
		ST_E_STEP,
		ST_E_KEY,
		ST_E_OUT
	} state_t;

endpackage

/* rtl/core/kbsc_ram.sv */
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module kbsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/keyed_byte_substitution_cipher_core.sv */
// keyed byte substitution cipher core: a data byte goes through E_RD, E_CAP, E_STEP, E_KEY
// (only when no step count is set) and E_OUT to the output register, set by dependent
// registered reads (map, step count, maybe a key byte); the next word is accepted in idle,
// reached once E_OUT finds the output register free. a start word runs clear (256
// entries), key pairs, repeat pass, scan, mix, two 64-bit remainders, fill, count sweep.
// arst_n clears control state, offset, cursor and counters; tables are built by start
module keyed_byte_substitution_cipher_core
	import kbsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // key_index[5:0], value[13:6], zero fill
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // data_out[7:0]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);

	state_t state_q, state_d;

	logic [LEN_W-1:0] klen_cfg_q, len_q, msg_len_q;
	logic             dir_q;
	logic [8:0]       idx_q, nds_q, ndt_q, n_q, nb_q;
	logic [7:0]       x_q, y_q, a_q, b_q, val_q, offset_q, res_q, out_q, r1_q, r2_q;
	logic             comp_q, pass_q, out_valid_q, dsel_q;
	logic [KEY_AW-1:0] cursor_q;
	logic [SUM_W-1:0] sum_q;
	logic [MIX_W-1:0] mix_q, dvd_q;
	logic [8:0]       rem_q;
	logic [DIV_CW-1:0] dcnt_q;

	logic [KEY_AW-1:0] key_raddr;
	logic [7:0]        key_rd;
	logic              fwd_we, inv_we;
	logic [7:0]        fwd_waddr, fwd_wdata, fwd_raddr, fwd_rd;
	logic [7:0]        inv_waddr, inv_wdata, inv_raddr, inv_rd;
	logic              stp_we;
	logic [7:0]        stp_waddr, stp_raddr;
	logic [8:0]        stp_wdata, stp_rd;
	logic              usr_we, utg_we, usr_wdata, utg_wdata, usr_rd, utg_rd;
	logic [7:0]        usr_waddr, utg_waddr, usr_raddr, utg_raddr;
	logic              dsr_we, dtg_we;
	logic [7:0]        dsr_waddr, dtg_waddr, dsr_wdata, dtg_wdata, dsr_raddr, dtg_raddr;
	logic [7:0]        dsr_rd, dtg_rd;

	logic              s_acc, key_we;
	logic [1:0]        req;
	logic [5:0]        in_idx;
	logic [7:0]        in_val;
	logic [LEN_W-1:0]  eff_len;
	logic [KEY_AW-1:0] kidx_nx, curs_nx;
	logic              both_free, idx_last_key, div_last;
	logic [7:0]        tally_inc_a;
	logic [8:0]        tally_a, tally_b, min_n;
	logic [9:0]        fsa, fja, rem_sh;
	logic [8:0]        fsrc, fj, ftix, rem_new;
	logic [7:0]        res_enc, dec_addr, res_cap;
	logic [MIX_W-1:0]  mix_mul;

	assign req      = s_tuser;
	assign in_idx   = s_tdata[5:0];
	assign in_val   = s_tdata[13:6];
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign key_we   = s_acc && (req == REQ_LOAD);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	assign eff_len = (klen_cfg_q == '0) ? LEN_W'(1) :
		(klen_cfg_q > LEN_W'(KEY_MAX_LEN)) ? LEN_W'(KEY_MAX_LEN) : klen_cfg_q;
	assign kidx_nx = ((idx_q + 9'd1) < {2'b0, len_q}) ? KEY_AW'(idx_q + 9'd1) : '0;
	assign curs_nx = ({1'b0, cursor_q} + 7'd1 == msg_len_q) ? '0 : cursor_q + 1'b1;
	assign idx_last_key = ((idx_q + 9'd1) == {2'b0, len_q});
	assign both_free = !usr_rd && !utg_rd;
	assign tally_inc_a = (a_q == b_q) ? 8'd2 : 8'd1;
	assign tally_a = stp_rd[8] ? {1'b1, stp_rd[7:0] + tally_inc_a} : STEP_FIRST;
	assign tally_b = stp_rd[8] ? {1'b1, stp_rd[7:0] + 8'd1} : STEP_FIRST;
	assign min_n = (n_q < nb_q) ? n_q : nb_q;

	// fill list positions, both sums stay below twice the fill size
	assign fsa  = {1'b0, idx_q} + {2'b0, r1_q};
	assign fsrc = (fsa >= {1'b0, n_q}) ? 9'(fsa - {1'b0, n_q}) : fsa[8:0];
	assign fja  = {1'b0, idx_q} + {1'b0, n_q} - {2'b0, r2_q};
	assign fj   = (fja >= {1'b0, n_q}) ? 9'(fja - {1'b0, n_q}) : fja[8:0];
	assign ftix = n_q - 9'd1 - fj;

	// shared restoring remainder step
	assign rem_sh  = {rem_q, dvd_q[MIX_W-1]};
	assign rem_new = (rem_sh >= {1'b0, n_q}) ? 9'(rem_sh - {1'b0, n_q}) : rem_sh[8:0];
	assign div_last = (dcnt_q == '1);

	assign mix_mul  = mix_q * {{(MIX_W-8){1'b0}}, key_rd};
	assign res_enc  = fwd_rd + offset_q;
	assign dec_addr = val_q - offset_q;
	assign res_cap  = dir_q ? inv_rd : res_enc;

	kbsc_ram #(.WIDTH(8), .DEPTH(KEY_MAX_LEN)) u_key (
		.clk, .we(key_we), .waddr(in_idx), .wdata(in_val), .raddr(key_raddr), .rdata(key_rd));
	kbsc_ram #(.WIDTH(8), .DEPTH(BYTE_VALS)) u_fwd (
		.clk, .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata), .raddr(fwd_raddr),
		.rdata(fwd_rd));
	kbsc_ram #(.WIDTH(8), .DEPTH(BYTE_VALS)) u_inv (
		.clk, .we(inv_we), .waddr(inv_waddr), .wdata(inv_wdata), .raddr(inv_raddr),
		.rdata(inv_rd));
	kbsc_ram #(.WIDTH(9), .DEPTH(BYTE_VALS)) u_stp (
		.clk, .we(stp_we), .waddr(stp_waddr), .wdata(stp_wdata), .raddr(stp_raddr),
		.rdata(stp_rd));
	kbsc_ram #(.WIDTH(1), .DEPTH(BYTE_VALS)) u_usr (
		.clk, .we(usr_we), .waddr(usr_waddr), .wdata(usr_wdata), .raddr(usr_raddr),
		.rdata(usr_rd));
	kbsc_ram #(.WIDTH(1), .DEPTH(BYTE_VALS)) u_utg (
		.clk, .we(utg_we), .waddr(utg_waddr), .wdata(utg_wdata), .raddr(utg_raddr),
		.rdata(utg_rd));
	kbsc_ram #(.WIDTH(8), .DEPTH(BYTE_VALS)) u_dsr (
		.clk, .we(dsr_we), .waddr(dsr_waddr), .wdata(dsr_wdata), .raddr(dsr_raddr),
		.rdata(dsr_rd));
	kbsc_ram #(.WIDTH(8), .DEPTH(BYTE_VALS)) u_dtg (
		.clk, .we(dtg_we), .waddr(dtg_waddr), .wdata(dtg_wdata), .raddr(dtg_raddr),
		.rdata(dtg_rd));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_acc && req == REQ_START) state_d = ST_CLR;
				else if (s_acc && req == REQ_DATA) state_d = ST_E_RD;
			end
			ST_CLR:    if (idx_q[7:0] == 8'hFF) state_d = ST_KX;
			ST_KX:     state_d = ST_KY;
			ST_KY:     state_d = ST_KYW;
			ST_KYW:    state_d = ST_P_RD;
			ST_P_RD:   state_d = ST_P_DEC;
			ST_P_DEC:  state_d = both_free ? ST_P_NEXT : ST_TA_RD;
			ST_TA_RD:  state_d = ST_TA_WR;
			ST_TA_WR:  state_d = (a_q == b_q) ? ST_P_NEXT : ST_TB_RD;
			ST_TB_RD:  state_d = ST_TB_WR;
			ST_TB_WR:  state_d = ST_P_NEXT;
			ST_P_NEXT: begin
				if (!comp_q) state_d = ST_P_RD;
				else if (!pass_q) begin
					if (!idx_last_key) state_d = ST_KX;
					else if (nds_q == ndt_q && nds_q != '0) state_d = ST_D_RD;
					else state_d = ST_S_RD;
				end else begin
					state_d = ((idx_q + 9'd1) == nds_q) ? ST_S_RD : ST_D_RD;
				end
			end
			ST_D_RD:   state_d = ST_D_CAP;
			ST_D_CAP:  state_d = ST_P_RD;
			ST_S_RD:   state_d = ST_S_WR;
			ST_S_WR:   state_d = (idx_q[7:0] == 8'hFF) ? ST_M_RD : ST_S_RD;
			ST_M_RD:   state_d = ST_M_ACC;
			ST_M_ACC:  begin
				if (idx_last_key) state_d = (n_q == '0) ? ST_N_RD : ST_DV;
				else state_d = ST_M_RD;
			end
			ST_DV:     if (div_last && dsel_q) state_d = (min_n == '0) ? ST_N_RD : ST_F_RD;
			ST_F_RD:   state_d = ST_F_WR;
			ST_F_WR:   state_d = ((idx_q + 9'd1) == min_n) ? ST_N_RD : ST_F_RD;
			ST_N_RD:   state_d = ST_N_WR;
			ST_N_WR:   state_d = (idx_q[7:0] == 8'hFF) ? ST_IDLE : ST_N_RD;
			ST_E_RD:   state_d = ST_E_CAP;
			ST_E_CAP:  state_d = ST_E_STEP;
			ST_E_STEP: state_d = stp_rd[8] ? ST_E_OUT : ST_E_KEY;
			ST_E_KEY:  state_d = ST_E_OUT;
			ST_E_OUT:  if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		key_raddr = '0;
		fwd_we = 1'b0; fwd_waddr = a_q; fwd_wdata = b_q; fwd_raddr = val_q;
		inv_we = 1'b0; inv_waddr = b_q; inv_wdata = a_q; inv_raddr = dec_addr;
		stp_we = 1'b0; stp_waddr = a_q; stp_wdata = tally_a; stp_raddr = a_q;
		usr_we = 1'b0; usr_waddr = a_q; usr_wdata = 1'b1; usr_raddr = a_q;
		utg_we = 1'b0; utg_waddr = b_q; utg_wdata = 1'b1; utg_raddr = b_q;
		dsr_we = 1'b0; dsr_waddr = nds_q[7:0]; dsr_wdata = a_q; dsr_raddr = idx_q[7:0];
		dtg_we = 1'b0; dtg_waddr = ndt_q[7:0]; dtg_wdata = b_q; dtg_raddr = idx_q[7:0];
		case (state_q)
			ST_CLR: begin
				stp_we = 1'b1; stp_waddr = idx_q[7:0]; stp_wdata = '0;
				usr_we = 1'b1; usr_waddr = idx_q[7:0]; usr_wdata = 1'b0;
				utg_we = 1'b1; utg_waddr = idx_q[7:0]; utg_wdata = 1'b0;
			end
			ST_KX: key_raddr = idx_q[KEY_AW-1:0];
			ST_KY: key_raddr = kidx_nx;
			ST_P_DEC: begin
				if (both_free) begin
					fwd_we = 1'b1; inv_we = 1'b1; usr_we = 1'b1; utg_we = 1'b1;
				end else if (!pass_q) begin
					dsr_we = !usr_rd && (nds_q != 9'd256);
					dtg_we = !utg_rd && (ndt_q != 9'd256);
				end
			end
			ST_TA_WR: stp_we = 1'b1;
			ST_TB_RD: stp_raddr = b_q;
			ST_TB_WR: begin
				stp_we = 1'b1; stp_waddr = b_q; stp_wdata = tally_b;
			end
			ST_S_RD: begin
				usr_raddr = idx_q[7:0]; utg_raddr = idx_q[7:0];
			end
			ST_S_WR: begin
				dsr_we = !usr_rd; dsr_waddr = n_q[7:0]; dsr_wdata = idx_q[7:0];
				dtg_we = !utg_rd && (nb_q != 9'd256);
				dtg_waddr = nb_q[7:0]; dtg_wdata = idx_q[7:0];
			end
			ST_M_RD: key_raddr = idx_q[KEY_AW-1:0];
			ST_F_RD: begin
				dsr_raddr = fsrc[7:0]; dtg_raddr = ftix[7:0];
			end
			ST_F_WR: begin
				fwd_we = 1'b1; fwd_waddr = dsr_rd; fwd_wdata = dtg_rd;
				inv_we = 1'b1; inv_waddr = dtg_rd; inv_wdata = dsr_rd;
			end
			ST_N_RD: stp_raddr = idx_q[7:0];
			ST_N_WR: begin
				stp_we = stp_rd[8] && (stp_rd[7:0] == '0);
				stp_waddr = idx_q[7:0]; stp_wdata = {1'b1, 1'b0, len_q};
			end
			ST_E_CAP: stp_raddr = dir_q ? val_q : res_enc;
			ST_E_STEP: key_raddr = curs_nx;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			klen_cfg_q <= LEN_W'(1);
			dir_q <= 1'b0;
			len_q <= LEN_W'(1);
			msg_len_q <= LEN_W'(1);
			offset_q <= '0;
			cursor_q <= '0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			nds_q <= '0; ndt_q <= '0; n_q <= '0; nb_q <= '0;
			comp_q <= 1'b0; pass_q <= 1'b0; dsel_q <= 1'b0;
			dcnt_q <= '0; rem_q <= '0;
			sum_q <= '0; mix_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == CFG_KEY_LENGTH) klen_cfg_q <= cfg_data;
			if (cfg_we && cfg_index == CFG_DIRECTION) dir_q <= cfg_data[0];
			if (state_q == ST_E_OUT && (!out_valid_q || m_tready)) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					val_q <= in_val;
					idx_q <= '0;
					if (s_acc && req == REQ_START) begin
						len_q <= eff_len;
						nds_q <= '0; ndt_q <= '0; pass_q <= 1'b0;
					end
				end
				ST_CLR: idx_q <= (idx_q[7:0] == 8'hFF) ? '0 : idx_q + 9'd1;
				ST_KY:  x_q <= key_rd;
				ST_KYW: begin
					y_q <= key_rd; a_q <= x_q; b_q <= key_rd; comp_q <= 1'b0;
				end
				ST_P_DEC: begin
					if (!both_free && !pass_q) begin
						if (!usr_rd && nds_q != 9'd256) nds_q <= nds_q + 9'd1;
						if (!utg_rd && ndt_q != 9'd256) ndt_q <= ndt_q + 9'd1;
					end
				end
				ST_P_NEXT: begin
					if (!comp_q) begin
						a_q <= ~x_q; b_q <= ~y_q; comp_q <= 1'b1;
					end else if (!pass_q) begin
						if (!idx_last_key) idx_q <= idx_q + 9'd1;
						else begin
							idx_q <= '0;
							n_q <= '0; nb_q <= '0;
							if (nds_q == ndt_q && nds_q != '0) pass_q <= 1'b1;
						end
					end else begin
						idx_q <= ((idx_q + 9'd1) == nds_q) ? '0 : idx_q + 9'd1;
						n_q <= '0; nb_q <= '0;
					end
				end
				ST_D_CAP: begin
					x_q <= dsr_rd; y_q <= dtg_rd; a_q <= dsr_rd; b_q <= dtg_rd;
					comp_q <= 1'b0;
				end
				ST_S_WR: begin
					if (!usr_rd) n_q <= n_q + 9'd1;
					if (!utg_rd && nb_q != 9'd256) nb_q <= nb_q + 9'd1;
					idx_q <= (idx_q[7:0] == 8'hFF) ? '0 : idx_q + 9'd1;
					sum_q <= '0; mix_q <= '0;
				end
				ST_M_ACC: begin
					sum_q <= sum_q + SUM_W'(key_rd);
					mix_q <= idx_q[0] ? mix_q + MIX_W'(key_rd) : mix_mul;
					idx_q <= idx_last_key ? '0 : idx_q + 9'd1;
					dvd_q <= MIX_W'(sum_q + SUM_W'(key_rd));
					rem_q <= '0; dcnt_q <= '0; dsel_q <= 1'b0;
					r1_q <= '0; r2_q <= '0;
				end
				ST_DV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (div_last) begin
						rem_q <= '0;
						if (!dsel_q) begin
							r1_q <= rem_new[7:0]; dvd_q <= mix_q; dsel_q <= 1'b1;
						end else begin
							r2_q <= rem_new[7:0];
						end
					end else begin
						rem_q <= rem_new;
						dvd_q <= {dvd_q[MIX_W-2:0], 1'b0};
					end
				end
				ST_F_WR: idx_q <= ((idx_q + 9'd1) == min_n) ? '0 : idx_q + 9'd1;
				ST_N_WR: begin
					idx_q <= idx_q + 9'd1;
					if (idx_q[7:0] == 8'hFF) begin
						offset_q <= '0; cursor_q <= '0; msg_len_q <= len_q;
					end
				end
				ST_E_CAP: res_q <= res_cap;
				ST_E_STEP: begin
					if (stp_rd[8]) offset_q <= offset_q + stp_rd[7:0];
					else cursor_q <= curs_nx;
				end
				ST_E_KEY: offset_q <= offset_q + key_rd;
				ST_E_OUT: begin
					if (!out_valid_q || m_tready) out_q <= res_q;
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_data_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && req == REQ_DATA) |=> (state_q == ST_E_RD))
		else $error("data word did not start the lookup");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DV) |-> (rem_q < n_q))
		else $error("remainder not below fill size");
	a_fill_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_F_RD) |-> (fsrc < n_q && ftix < n_q))
		else $error("fill list position out of range");
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != '0 && len_q <= LEN_W'(KEY_MAX_LEN)))
		else $error("latched key length out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(out_q)))
		else $error("pending result lost");
`endif

endmodule

/* test/keyed_byte_substitution_cipher_core_tb.sv */
`timescale 1ns / 100ps
// self-checking bench for the keyed byte substitution cipher core: random key loads,
// table builds and data bytes in both directions, checked against a built-in predictor
// depends on kbsc_pkg and keyed_byte_substitution_cipher_core
module keyed_byte_substitution_cipher_core_tb;
	import kbsc_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] idx;
		logic [7:0] val;
	} word_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        cfg_we;
	logic        cfg_index;
	logic [6:0]  cfg_data;

	keyed_byte_substitution_cipher_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [7:0] key_bytes [KEY_MAX_LEN];
	logic [7:0] fwd_sbox [256];
	logic [7:0] inv_sbox [256];
	logic [8:0] step_tab [256];
	logic       src_taken [256];
	logic       dst_taken [256];
	logic [7:0] held_src [256];
	logic [7:0] held_dst [256];
	int unsigned n_held_src, n_held_dst;
	logic [7:0] offset;
	int unsigned cursor;
	int unsigned msg_keylen;
	int unsigned cfg_keylen;
	bit          cfg_decrypt;

	word_t      pending_words [$];
	logic [7:0] expected_bytes [$];
	int  errors, cycle, words_sent, bytes_seen, encrypt_bytes, decrypt_bytes, builds;
	bit  hold_off;

	function automatic void put_word(logic [1:0] k, logic [5:0] i, logic [7:0] v);
		word_t w;
		w.kind = k;
		w.idx = i;
		w.val = v;
		pending_words = {pending_words, w};
	endfunction

	function automatic void bump(logic [7:0] x, int inc);
		if (step_tab[x][8])
			step_tab[x] = {1'b1, step_tab[x][7:0] + 8'(inc)};
		else
			step_tab[x] = STEP_FIRST;
	endfunction

	function automatic void offer_pair(logic [7:0] a, logic [7:0] b, bit defer);
		bit ha, hb;
		ha = src_taken[a];
		hb = dst_taken[b];
		if (!ha && !hb) begin
			fwd_sbox[a] = b;
			inv_sbox[b] = a;
			src_taken[a] = 1;
			dst_taken[b] = 1;
			return;
		end
		if (defer) begin
			if (!ha && n_held_src < 256) begin
				held_src[n_held_src] = a;
				n_held_src++;
			end
			if (!hb && n_held_dst < 256) begin
				held_dst[n_held_dst] = b;
				n_held_dst++;
			end
		end
		if (a == b) begin
			bump(a, 2);
		end else begin
			bump(a, 1);
			bump(b, 1);
		end
	endfunction

	function automatic void build_schedule();
		logic [7:0] fa [256];
		logic [7:0] fb [256];
		int unsigned n, nb, r1, r2, j, len, c;
		logic [63:0] sum, mix;
		logic [7:0] x, y, s, t;
		len = cfg_keylen;
		if (len == 0) len = 1;
		if (len > KEY_MAX_LEN) len = KEY_MAX_LEN;
		msg_keylen = len;
		n = 0;
		nb = 0;
		sum = 0;
		mix = 0;
		for (int i = 0; i < 256; i++) begin
			step_tab[i] = 0;
			src_taken[i] = 0;
			dst_taken[i] = 0;
		end
		n_held_src = 0;
		n_held_dst = 0;
		for (int i = 0; i < len; i++) begin
			x = key_bytes[i];
			y = key_bytes[(i + 1 < len) ? i + 1 : 0];
			offer_pair(x, y, 1);
			offer_pair(8'd255 - x, 8'd255 - y, 1);
		end
		if (n_held_src == n_held_dst)
			for (int i = 0; i < n_held_src; i++) begin
				x = held_src[i];
				y = held_dst[i];
				offer_pair(x, y, 0);
				offer_pair(8'd255 - x, 8'd255 - y, 0);
			end
		for (int i = 0; i < 256; i++) begin
			if (!src_taken[i]) begin
				fa[n] = 8'(i);
				n++;
			end
			if (!dst_taken[i]) begin
				fb[nb] = 8'(i);
				nb++;
			end
		end
		for (int i = 0; i < len; i++) begin
			sum += key_bytes[i];
			if (i & 1) mix += key_bytes[i];
			else mix *= key_bytes[i];
		end
		r1 = (n != 0) ? int'(sum % n) : 0;
		r2 = (n != 0) ? int'(mix % n) : 0;
		for (int i = 0; i < n && i < nb; i++) begin
			s = fa[(i + r1) % n];
			j = (i + n - r2) % n;
			t = fb[(n - 1 - j) & 8'hff];
			fwd_sbox[s] = t;
			inv_sbox[t] = s;
			src_taken[s] = 1;
			dst_taken[t] = 1;
		end
		for (int i = 0; i < 256; i++)
			if (step_tab[i][8]) begin
				c = step_tab[i][7:0];
				if (c == 0) c = len & 8'hff;
				step_tab[i] = {1'b1, 8'(c)};
			end
		offset = 0;
		cursor = 0;
	endfunction

	function automatic logic [7:0] advance_of(logic [7:0] x);
		if (step_tab[x][8]) return step_tab[x][7:0];
		cursor = (cursor + 1) % msg_keylen;
		return key_bytes[cursor];
	endfunction

	function automatic void predict_word(word_t w);
		logic [7:0] r;
		case (w.kind)
			REQ_LOAD: begin
				key_bytes[w.idx] = w.val;
			end
			REQ_START: begin
				build_schedule();
				builds++;
			end
			REQ_DATA: begin
				if (!cfg_decrypt) begin
					r = fwd_sbox[w.val] + offset;
					offset = offset + advance_of(r);
					encrypt_bytes++;
				end else begin
					r = inv_sbox[w.val - offset];
					offset = offset + advance_of(w.val);
					decrypt_bytes++;
				end
				expected_bytes = {expected_bytes, r};
			end
			default: ;
		endcase
	endfunction

	initial clk = 0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 3000000) begin
			$display("%0t timeout", $time);
			$display("TB_ERROR");
			$finish;
		end
	end

	// driver
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= 0;
			s_tuser <= 0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_word(pending_words.pop_front());
				words_sent <= words_sent + 1;
			end
			if (s_tvalid && !s_tready) begin
			end else if (send_gap > 0) begin
				s_tvalid <= 0;
				send_gap <= send_gap - 1;
			end else if (pending_words.size() > 0) begin
				s_tvalid <= 1;
				s_tuser <= pending_words[0].kind;
				s_tdata <= {2'b0, pending_words[0].val, pending_words[0].idx};
				send_gap <= $urandom_range(0, 4);
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	// monitor
	int recv_gap, hold_cnt;
	logic [7:0] want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			recv_gap <= 0;
			hold_cnt <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				bytes_seen <= bytes_seen + 1;
				if (expected_bytes.size() == 0) begin
					$display("%0t unexpected byte: expected none, actual %02h", $time, m_tdata);
					errors <= errors + 1;
				end else begin
					want = expected_bytes.pop_front();
					if (want !== m_tdata) begin
						$display("%0t data_out mismatch: expected %02h, actual %02h",
							$time, want, m_tdata);
						errors <= errors + 1;
					end
				end
				recv_gap <= $urandom_range(0, 4);
			end
			if (hold_off && hold_cnt < 400) begin
				if (m_tvalid) hold_cnt <= hold_cnt + 1;
				m_tready <= 0;
			end else if (recv_gap > 0 && !(m_tvalid && m_tready)) begin
				m_tready <= 0;
				recv_gap <= recv_gap - 1;
			end else begin
				m_tready <= !(m_tvalid && m_tready) || ($urandom_range(0, 3) == 0);
			end
		end
	end

	task automatic write_reg(logic idx, logic [6:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == CFG_KEY_LENGTH) cfg_keylen = v;
		else cfg_decrypt = v[0];
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || expected_bytes.size() > 0) @(posedge clk);
		repeat (3200) @(posedge clk);
	endtask

	task automatic queue_key(int len);
		for (int i = 0; i < len; i++)
			put_word(REQ_LOAD, 6'(i), 8'($urandom));
	endtask

	task automatic queue_data(int cnt);
		for (int i = 0; i < cnt; i++)
			put_word(REQ_DATA, 6'($urandom), 8'($urandom));
	endtask

	int len;
	initial begin
		errors = 0; cycle = 0; words_sent = 0; bytes_seen = 0;
		encrypt_bytes = 0; decrypt_bytes = 0; builds = 0; hold_off = 0;
		cfg_keylen = 1; cfg_decrypt = 0; offset = 0; cursor = 0; msg_keylen = 1;
		n_held_src = 0; n_held_dst = 0;
		for (int i = 0; i < KEY_MAX_LEN; i++) key_bytes[i] = 0;
		for (int i = 0; i < 256; i++) begin
			fwd_sbox[i] = 0; inv_sbox[i] = 0; step_tab[i] = 0;
			src_taken[i] = 0; dst_taken[i] = 0;
		end
		cfg_we = 0; cfg_index = 0; cfg_data = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// directed: extreme key bytes, length 1 and reset length, ignored kind and index
		write_reg(CFG_KEY_LENGTH, 7'd1);
		write_reg(CFG_DIRECTION, 1'b0);
		put_word(REQ_LOAD, 6'd0, 8'hff);
		put_word(REQ_LOAD, 6'd63, 8'h00);
		put_word(REQ_START, 6'd0, 8'd0);
		put_word(REQ_DATA, 6'd0, 8'h00);
		put_word(REQ_DATA, 6'h3f, 8'hff);
		put_word(REQ_UNUSED, 6'h2a, 8'h55);
		put_word(REQ_DATA, 6'h15, 8'haa);
		put_word(REQ_LOAD, 6'd0, 8'h80);
		put_word(REQ_DATA, 6'd0, 8'h7f);
		drain();
		// length 0 acts as 1, out-of-range lengths clamp at 64; repeated key pairs
		write_reg(CFG_KEY_LENGTH, 7'd0);
		put_word(REQ_START, 6'd0, 8'd0);
		queue_data(3);
		drain();
		for (int i = 0; i < KEY_MAX_LEN; i++)
			put_word(REQ_LOAD, 6'(i), 8'((i % 3) * 85));
		drain();
		write_reg(CFG_KEY_LENGTH, 7'd127);
		put_word(REQ_START, 6'd0, 8'd0);
		queue_data(4);
		drain();

		// random phases with both directions and a long stall
		for (int ph = 0; ph < 10; ph++) begin
			len = (ph == 0) ? 64 : (ph == 1) ? 1 : $urandom_range(1, 12);
			queue_key(len);
			drain();
			write_reg(CFG_KEY_LENGTH, 7'(len));
			write_reg(CFG_DIRECTION, 1'($urandom));
			put_word(REQ_START, 6'd0, 8'd0);
			if (ph == 3) hold_off = 1;
			queue_data(25);
			if ($urandom_range(0, 2) == 0)
				put_word(REQ_LOAD, 6'($urandom_range(0, len - 1)), 8'($urandom));
			if ($urandom_range(0, 3) == 0) put_word(REQ_UNUSED, 6'($urandom), 8'($urandom));
			if ($urandom_range(0, 2) == 0) begin
				put_word(REQ_START, 6'd0, 8'd0);
				queue_data(10);
			end
			drain();
		end

		$display("%0d words sent, %0d builds, %0d bytes checked (%0d encrypt, %0d decrypt)",
			words_sent, builds, bytes_seen, encrypt_bytes, decrypt_bytes);
		$display("key lengths 0..127 clamped, both directions, long output stall included");
		if (errors == 0 && expected_bytes.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* keyed_byte_substitution_cipher_core.f */
rtl/core/kbsc_pkg.sv
rtl/core/kbsc_ram.sv
rtl/core/keyed_byte_substitution_cipher_core.sv
test/keyed_byte_substitution_cipher_core_tb.sv
